// ===== hw/rtl/mi3_pkg.sv =====
`default_nettype none
package mi3_pkg;

  // entry and intermediate widths
  localparam int unsigned EW = 16;   // input entry, Q2.14
  localparam int unsigned PW = 32;   // product of two entries
  localparam int unsigned AW = 33;   // cofactor
  localparam int unsigned DW = 50;   // determinant, signed
  localparam int unsigned RW = 49;   // divisor and remainder, unsigned
  localparam int unsigned NW = 63;   // scaled numerator
  localparam int unsigned QW = 32;   // quotient, Q16.16
  localparam int unsigned TW = 31;   // det_threshold
  localparam int unsigned SW = 15;   // sym_tolerance
  localparam int unsigned NE = 9;    // entries of a 3x3 matrix

  // divider pipeline: one setup stage, then one quotient bit per stage
  localparam int unsigned NS = QW + 1;

  // register indexes
  localparam logic CFG_DET_THR = 1'b0;
  localparam logic CFG_SYM_TOL = 1'b1;

  localparam logic [TW-1:0] DET_THR_RST = TW'(268);
  localparam logic [SW-1:0] SYM_TOL_RST = SW'(1);

  // adjugate entry k = m[A]*m[B] - m[C]*m[D], k = row*3 + col, entries row-major
  localparam int unsigned CF_A [NE] = '{4, 7, 5, 5, 8, 3, 3, 6, 4};
  localparam int unsigned CF_B [NE] = '{8, 2, 1, 6, 0, 2, 7, 1, 0};
  localparam int unsigned CF_C [NE] = '{5, 8, 4, 3, 6, 5, 4, 7, 3};
  localparam int unsigned CF_D [NE] = '{7, 1, 2, 8, 2, 0, 6, 0, 1};

  typedef logic [NE-1:0][EW-1:0] mat_t;
  typedef logic [2:0][EW-1:0]    row_t;
  typedef logic [NE-1:0][AW-1:0] adj_t;

  typedef struct packed {
    row_t row0;
    adj_t adj;
  } cof_t;

  typedef struct packed {
    adj_t          adj;
    logic [DW-1:0] det;
    logic          ok;
  } dsum_t;

  typedef struct packed {
    logic [NE-1:0][RW-1:0] rem;
    logic [NE-1:0][QW-1:0] nq;
    logic [NE-1:0]         ovf;
    logic [NE-1:0]         neg;
    logic [RW-1:0]         d;
    logic                  ok;
  } div_st_t;

  typedef struct packed {
    logic [NE-1:0][QW-1:0] q;
    logic [NE-1:0]         ovf;
    logic [NE-1:0]         neg;
    logic                  ok;
  } div_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mi3_if.sv =====
`default_nettype none
interface mi3_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface mi3_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic              valid_res;
  logic              saturated;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  valid_res, saturated, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                valid_res, saturated, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mi3_cofactor.sv =====
`default_nettype none
module mi3_cofactor (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [mi3_pkg::SW-1:0] sym_tol,
  input  wire logic                   i_valid,
  output logic                        i_ready,
  input  wire mi3_pkg::mat_t          i_mat,
  output logic                        o_valid,
  input  wire logic                   o_ready,
  output mi3_pkg::cof_t               o_data
);
  import mi3_pkg::*;

  logic [2:0]               v_r;
  logic [2:0]               ld;
  mat_t                     m_r;
  logic [2*NE-1:0][PW-1:0]  prod_r, prod_nxt;
  row_t                     row_r;
  logic                     sym_r, sym_nxt;
  cof_t                     out_r, out_nxt;

  function automatic logic pair_close(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                      input logic [SW-1:0] tol);
    logic signed [EW:0] diff;
    logic [EW:0]        mag;
    diff = $signed({a[EW-1], a}) - $signed({b[EW-1], b});
    mag  = diff[EW] ? (~diff + 1'b1) : diff;
    return mag < {2'b00, tol};
  endfunction

  // stage handshake
  always_comb begin
    ld[2] = !v_r[2] || o_ready;
    ld[1] = !v_r[1] || ld[2];
    ld[0] = !v_r[0] || ld[1];
  end
  assign i_ready = ld[0];
  assign o_valid = v_r[2];
  assign o_data  = out_r;

  // entry products and symmetry test
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      prod_nxt[2*k]   = PW'($signed(m_r[CF_A[k]]) * $signed(m_r[CF_B[k]]));
      prod_nxt[2*k+1] = PW'($signed(m_r[CF_C[k]]) * $signed(m_r[CF_D[k]]));
    end
    sym_nxt = pair_close(m_r[1], m_r[3], sym_tol) &&
              pair_close(m_r[2], m_r[6], sym_tol) &&
              pair_close(m_r[5], m_r[7], sym_tol);
  end

  // cofactor differences, upper triangle copied from the lower triangle when symmetric
  always_comb begin
    out_nxt.row0 = row_r;
    for (int k = 0; k < NE; k++) begin
      out_nxt.adj[k] = $signed({prod_r[2*k][PW-1], prod_r[2*k]}) -
                       $signed({prod_r[2*k+1][PW-1], prod_r[2*k+1]});
    end
    if (sym_r) begin
      out_nxt.adj[1] = out_nxt.adj[3];
      out_nxt.adj[2] = out_nxt.adj[6];
      out_nxt.adj[5] = out_nxt.adj[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= i_valid;
      if (ld[1]) v_r[1] <= v_r[0];
      if (ld[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) m_r <= i_mat;
    if (ld[1]) begin
      prod_r <= prod_nxt;
      row_r  <= m_r[2:0];
      sym_r  <= sym_nxt;
    end
    if (ld[2]) out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mi3_det.sv =====
`default_nettype none
module mi3_det (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [mi3_pkg::TW-1:0] det_thr,
  input  wire logic                   i_valid,
  output logic                        i_ready,
  input  wire mi3_pkg::cof_t          i_data,
  output logic                        o_valid,
  input  wire logic                   o_ready,
  output mi3_pkg::dsum_t              o_data
);
  import mi3_pkg::*;

  localparam int unsigned XW = EW + AW;

  logic [1:0]              v_r;
  logic [1:0]              ld;
  logic [2:0][XW-1:0]      dp_r, dp_nxt;
  adj_t                    adj_r;
  dsum_t                   out_r, out_nxt;
  logic signed [DW-1:0]    det_s;
  logic signed [DW-1:0]    thr_s;

  always_comb begin
    ld[1] = !v_r[1] || o_ready;
    ld[0] = !v_r[0] || ld[1];
  end
  assign i_ready = ld[0];
  assign o_valid = v_r[1];
  assign o_data  = out_r;

  // first-row expansion products
  always_comb begin
    dp_nxt[0] = XW'($signed(i_data.row0[0]) * $signed(i_data.adj[0]));
    dp_nxt[1] = XW'($signed(i_data.row0[1]) * $signed(i_data.adj[3]));
    dp_nxt[2] = XW'($signed(i_data.row0[2]) * $signed(i_data.adj[6]));
  end

  // determinant sum and threshold test
  always_comb begin
    det_s = $signed({{(DW-XW){dp_r[0][XW-1]}}, dp_r[0]}) +
            $signed({{(DW-XW){dp_r[1][XW-1]}}, dp_r[1]}) +
            $signed({{(DW-XW){dp_r[2][XW-1]}}, dp_r[2]});
    thr_s = $signed({{(DW-TW-14){1'b0}}, det_thr, 14'b0});
    out_nxt.adj = adj_r;
    out_nxt.det = det_s;
    out_nxt.ok  = (det_s > 0) && (det_s >= thr_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= i_valid;
      if (ld[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dp_r  <= dp_nxt;
      adj_r <= i_data.adj;
    end
    if (ld[1]) out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mi3_divider.sv =====
`default_nettype none
module mi3_divider (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           i_valid,
  output logic                i_ready,
  input  wire mi3_pkg::dsum_t i_data,
  output logic                o_valid,
  input  wire logic           o_ready,
  output mi3_pkg::div_res_t   o_data
);
  import mi3_pkg::*;

  logic [NS-1:0] v_r;
  logic [NS-1:0] ld;
  div_st_t       st_r   [NS];
  div_st_t       st_nxt [NS];

  // stall chain, last stage first
  always_comb begin
    ld[NS-1] = !v_r[NS-1] || o_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end
  assign i_ready = ld[0];
  assign o_valid = v_r[NS-1];

  always_comb begin
    logic [AW-1:0]     a;
    logic [AW-1:0]     mag;
    logic [NW-1:0]     num;
    logic [NW-QW-1:0]  hi;
    logic [RW:0]       t;
    logic [RW:0]       diff;
    logic              ge;
    // setup: magnitude scaled by 2^30 plus half divisor, overflow check
    st_nxt[0].d  = i_data.det[RW-1:0];
    st_nxt[0].ok = i_data.ok;
    for (int l = 0; l < NE; l++) begin
      a   = i_data.adj[l];
      mag = a[AW-1] ? (~a + 1'b1) : a;
      num = {1'b0, mag[QW-1:0], 30'b0} +
            {{(NW-RW+1){1'b0}}, i_data.det[RW-1:1]};
      hi  = num[NW-1:QW];
      st_nxt[0].neg[l] = a[AW-1];
      st_nxt[0].ovf[l] = {{(RW-NW+QW){1'b0}}, hi} >= i_data.det[RW-1:0];
      st_nxt[0].rem[l] = st_nxt[0].ovf[l] ? '0 : {{(RW-NW+QW){1'b0}}, hi};
      st_nxt[0].nq[l]  = num[QW-1:0];
    end
    // one restoring step per stage
    for (int k = 1; k < NS; k++) begin
      st_nxt[k].d   = st_r[k-1].d;
      st_nxt[k].ok  = st_r[k-1].ok;
      st_nxt[k].ovf = st_r[k-1].ovf;
      st_nxt[k].neg = st_r[k-1].neg;
      for (int l = 0; l < NE; l++) begin
        t    = {st_r[k-1].rem[l], st_r[k-1].nq[l][QW-1]};
        diff = t - {1'b0, st_r[k-1].d};
        ge   = t >= {1'b0, st_r[k-1].d};
        st_nxt[k].rem[l] = ge ? diff[RW-1:0] : t[RW-1:0];
        st_nxt[k].nq[l]  = {st_r[k-1].nq[l][QW-2:0], ge};
      end
    end
  end

  always_comb begin
    o_data.q   = st_r[NS-1].nq;
    o_data.ovf = st_r[NS-1].ovf;
    o_data.neg = st_r[NS-1].neg;
    o_data.ok  = st_r[NS-1].ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= i_valid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (ld[k]) st_r[k] <= st_nxt[k];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/matrix3x3_inverse_unit.sv =====
`default_nettype none
// pipeline from input beat to result beat: three cofactor stages, two determinant
//   stages, 33 divider stages and the output register
// throughput: one matrix per cycle unless out_ch.ready holds the pipeline; after its setup
//   stage the divider makes one quotient bit per stage, 32 stages, for all nine entries at once
// reset: synchronous active-low rst_n empties every stage and loads
//   det_threshold = 268 and sym_tolerance = 1
module matrix3x3_inverse_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mi3_in_if.sink           in_ch,
  mi3_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [30:0] cfg_data
);
  import mi3_pkg::*;

  logic [TW-1:0] det_thr_r;
  logic [SW-1:0] sym_tol_r;

  mat_t     in_mat;
  logic     cof_valid, cof_ready;
  cof_t     cof_data;
  logic     det_valid, det_ready;
  dsum_t    det_data;
  logic     div_valid, div_ready;
  div_res_t div_data;

  logic                  out_v_r;
  logic [NE-1:0][QW-1:0] res_r, res_nxt;
  logic                  ok_r, sat_r, sat_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r <= DET_THR_RST;
      sym_tol_r <= SYM_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DET_THR: det_thr_r <= cfg_data[TW-1:0];
        CFG_SYM_TOL: sym_tol_r <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_mat[0] = in_ch.m00;
    in_mat[1] = in_ch.m01;
    in_mat[2] = in_ch.m02;
    in_mat[3] = in_ch.m10;
    in_mat[4] = in_ch.m11;
    in_mat[5] = in_ch.m12;
    in_mat[6] = in_ch.m20;
    in_mat[7] = in_ch.m21;
    in_mat[8] = in_ch.m22;
  end

  mi3_cofactor u_cof (
    .clk     (clk),
    .rst_n   (rst_n),
    .sym_tol (sym_tol_r),
    .i_valid (in_ch.valid),
    .i_ready (in_ch.ready),
    .i_mat   (in_mat),
    .o_valid (cof_valid),
    .o_ready (cof_ready),
    .o_data  (cof_data)
  );

  mi3_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .det_thr (det_thr_r),
    .i_valid (cof_valid),
    .i_ready (cof_ready),
    .i_data  (cof_data),
    .o_valid (det_valid),
    .o_ready (det_ready),
    .o_data  (det_data)
  );

  mi3_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (det_valid),
    .i_ready (det_ready),
    .i_data  (det_data),
    .o_valid (div_valid),
    .o_ready (div_ready),
    .o_data  (div_data)
  );

  // sign and saturation of the quotients, zeroed when the matrix is rejected
  always_comb begin
    sat_nxt = 1'b0;
    for (int l = 0; l < NE; l++) begin
      if (div_data.neg[l]) begin
        if (div_data.ovf[l] || div_data.q[l] > {1'b1, {(QW-1){1'b0}}}) begin
          sat_nxt    = 1'b1;
          res_nxt[l] = {1'b1, {(QW-1){1'b0}}};
        end else begin
          res_nxt[l] = ~div_data.q[l] + 1'b1;
        end
      end else begin
        if (div_data.ovf[l] || div_data.q[l][QW-1]) begin
          sat_nxt    = 1'b1;
          res_nxt[l] = {1'b0, {(QW-1){1'b1}}};
        end else begin
          res_nxt[l] = div_data.q[l];
        end
      end
      if (!div_data.ok) res_nxt[l] = '0;
    end
    if (!div_data.ok) sat_nxt = 1'b0;
  end

  // output register
  assign div_ready = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (div_ready) begin
      out_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      res_r <= res_nxt;
      ok_r  <= div_data.ok;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.r00       = res_r[0];
  assign out_ch.r01       = res_r[1];
  assign out_ch.r02       = res_r[2];
  assign out_ch.r10       = res_r[3];
  assign out_ch.r11       = res_r[4];
  assign out_ch.r12       = res_r[5];
  assign out_ch.r20       = res_r[6];
  assign out_ch.r21       = res_r[7];
  assign out_ch.r22       = res_r[8];
  assign out_ch.valid_res = ok_r;
  assign out_ch.saturated = sat_r;

endmodule
`default_nettype wire
